>>> rtl/sfd_pkg.sv
// Shared types and constants for the sync frame deframer.
// No dependencies; every other file depends on this package.
`default_nettype none

package sfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_OUT_W = 11;
    localparam int WORD_W    = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_SYNC_FIRST       = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND      = 2'd1;
    localparam logic [1:0] CFG_VERSION_EXPECTED = 2'd2;

    localparam logic [2:0]        HDR_LAST       = 3'd5;
    localparam logic [WORD_W-1:0] CHECKSUM_EMPTY = 16'hffff;

    typedef enum logic [1:0] {
        V_NONE     = 2'd0,
        V_GOOD     = 2'd1,
        V_REJECT   = 2'd2,
        V_MISMATCH = 2'd3
    } t_verdict;

    typedef struct packed {
        logic                 payload_valid;
        logic [BYTE_W-1:0]    payload_byte;
        t_verdict             verdict;
        logic [BYTE_W-1:0]    frame_kind;
        logic [LEN_OUT_W-1:0] frame_length;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/sfd_byte_if.sv
// Input channel of the deframer: one received byte per item.
// Depends on sfd_pkg for the byte width.
`default_nettype none

interface sfd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [sfd_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/sfd_result_if.sv
// Output channel of the deframer: one result item per accepted byte.
// Depends on sfd_pkg for field widths and the verdict type.
`default_nettype none

interface sfd_result_if;
    logic                          valid;
    logic                          ready;
    logic                          payload_valid;
    logic [sfd_pkg::BYTE_W-1:0]    payload_byte;
    sfd_pkg::t_verdict             verdict;
    logic [sfd_pkg::BYTE_W-1:0]    frame_kind;
    logic [sfd_pkg::LEN_OUT_W-1:0] frame_length;

    modport source (output valid, output payload_valid, output payload_byte,
                    output verdict, output frame_kind, output frame_length,
                    input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input verdict, input frame_kind, input frame_length,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/sfd_core.sv
// Deframer state machine: sync hunt, header capture, payload checksum.
// Depends on sfd_pkg; the result is combinational from state and the byte.
`default_nettype none

module sfd_core #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [sfd_pkg::BYTE_W-1:0] i_cfg_data,
    input  wire logic                       i_accept,
    input  wire logic [sfd_pkg::BYTE_W-1:0] i_data_byte,
    output sfd_pkg::t_result                o_result
);
    import sfd_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    typedef enum logic [1:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    t_phase              r_phase,    n_phase;
    logic [2:0]          r_hdr_cnt,  n_hdr_cnt;
    logic [BYTE_W-1:0]   r_version,  n_version;
    logic [BYTE_W-1:0]   r_kind,     n_kind;
    logic [WORD_W-1:0]   r_length,   n_length;
    logic [WORD_W-1:0]   r_checksum, n_checksum;
    logic [CNT_W-1:0]    r_pay_cnt,  n_pay_cnt;
    logic [WORD_W-1:0]   r_sum,      n_sum;
    logic [BYTE_W-1:0]   r_sync_first, r_sync_second, r_version_exp;

    logic [WORD_W-1:0]   sum_add;
    logic [WORD_W:0]     sum_wide;
    logic [CNT_W-1:0]    cnt_inc;
    t_result             res;

    // ones-complement add with end-around carry; a second carry cannot occur
    assign sum_wide = {1'b0, r_sum} + {{(WORD_W + 1 - BYTE_W){1'b0}}, i_data_byte};
    assign sum_add  = sum_wide[WORD_W] ? (sum_wide[WORD_W-1:0] + 1'b1)
                                       : sum_wide[WORD_W-1:0];
    assign cnt_inc  = r_pay_cnt + 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_version  = r_version;
        n_kind     = r_kind;
        n_length   = r_length;
        n_checksum = r_checksum;
        n_pay_cnt  = r_pay_cnt;
        n_sum      = r_sum;
        res        = '0;
        res.verdict = V_NONE;

        unique case (r_phase)
            PH_HUNT1: begin
                if (i_data_byte == r_sync_first) n_phase = PH_HUNT2;
            end
            PH_HUNT2: begin
                // second sync byte wins when both sync bytes match
                if (i_data_byte == r_sync_second) begin
                    n_phase   = PH_HEADER;
                    n_hdr_cnt = '0;
                end else if (i_data_byte != r_sync_first) begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_HEADER: begin
                unique case (r_hdr_cnt)
                    3'd0:    n_version  = i_data_byte;
                    3'd1:    n_kind     = i_data_byte;
                    3'd2:    n_length   = {i_data_byte, r_length[BYTE_W-1:0]};
                    3'd3:    n_length   = {r_length[WORD_W-1:BYTE_W], i_data_byte};
                    3'd4:    n_checksum = {i_data_byte, r_checksum[BYTE_W-1:0]};
                    default: n_checksum = {r_checksum[WORD_W-1:BYTE_W], i_data_byte};
                endcase
                n_hdr_cnt = r_hdr_cnt + 1'b1;
                if (r_hdr_cnt >= HDR_LAST) begin
                    n_hdr_cnt = '0;
                    n_pay_cnt = '0;
                    n_sum     = '0;
                    if (r_version != r_version_exp ||
                        r_length > WORD_W'(MAX_PAYLOAD)) begin
                        n_phase     = PH_HUNT1;
                        res.verdict = V_REJECT;
                    end else if (r_length == '0) begin
                        n_phase = PH_HUNT1;
                        if (n_checksum != CHECKSUM_EMPTY) begin
                            res.verdict = V_MISMATCH;
                        end else begin
                            res.verdict    = V_GOOD;
                            res.frame_kind = r_kind;
                        end
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            default: begin
                res.payload_valid = 1'b1;
                res.payload_byte  = i_data_byte;
                n_sum     = sum_add;
                n_pay_cnt = cnt_inc;
                if (WORD_W'(cnt_inc) >= r_length) begin
                    n_phase = PH_HUNT1;
                    if (~sum_add != r_checksum) begin
                        res.verdict = V_MISMATCH;
                    end else begin
                        res.verdict      = V_GOOD;
                        res.frame_kind   = r_kind;
                        res.frame_length = r_length[LEN_OUT_W-1:0];
                    end
                end
            end
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT1;
            r_hdr_cnt     <= '0;
            r_version     <= '0;
            r_kind        <= '0;
            r_length      <= '0;
            r_checksum    <= '0;
            r_pay_cnt     <= '0;
            r_sum         <= '0;
            r_sync_first  <= '0;
            r_sync_second <= '0;
            r_version_exp <= '0;
        end else begin
            if (i_accept) begin
                r_phase    <= n_phase;
                r_hdr_cnt  <= n_hdr_cnt;
                r_version  <= n_version;
                r_kind     <= n_kind;
                r_length   <= n_length;
                r_checksum <= n_checksum;
                r_pay_cnt  <= n_pay_cnt;
                r_sum      <= n_sum;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SYNC_FIRST:       r_sync_first  <= i_cfg_data;
                    CFG_SYNC_SECOND:      r_sync_second <= i_cfg_data;
                    CFG_VERSION_EXPECTED: r_version_exp <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/sfd_skid.sv
// Two-entry output buffer: result register plus skid register.
// Depends on sfd_pkg for the result struct.
`default_nettype none

module sfd_skid (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire sfd_pkg::t_result i_result,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output sfd_pkg::t_result      o_result
);
    import sfd_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            // output slot frees: refill from skid first, else from the input
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out       <= i_result;
                r_out_valid <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid       <= i_result;
            r_skid_valid <= 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sync_frame_deframer_top.sv
// Top level of the sync frame deframer: channel interfaces and config port.
// Depends on sfd_pkg, sfd_byte_if, sfd_result_if, sfd_core and sfd_skid.
`default_nettype none

// One byte is taken per clock while the buffer has room; each gives exactly
// one result item, registered in the output or skid register. The hunt,
// header capture and checksum add form a single combinational step ahead of
// a two-entry output buffer: bytes flow with one result waiting, not two.
// Configuration writes take effect at the next edge; no memory, no clearing.
module sync_frame_deframer_top #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [sfd_pkg::BYTE_W-1:0] i_cfg_data,
    sfd_byte_if.sink                        i_byte_ch,
    sfd_result_if.source                    o_res_ch
);
    import sfd_pkg::*;

    logic    accept, buf_ready;
    t_result core_res, out_res;

    assign i_byte_ch.ready = buf_ready;
    assign accept          = i_byte_ch.valid && buf_ready;

    sfd_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_data_byte (i_byte_ch.data_byte),
        .o_result    (core_res)
    );

    sfd_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .o_ready  (buf_ready),
        .i_result (core_res),
        .o_valid  (o_res_ch.valid),
        .i_ready  (o_res_ch.ready),
        .o_result (out_res)
    );

    assign o_res_ch.payload_valid = out_res.payload_valid;
    assign o_res_ch.payload_byte  = out_res.payload_byte;
    assign o_res_ch.verdict       = out_res.verdict;
    assign o_res_ch.frame_kind    = out_res.frame_kind;
    assign o_res_ch.frame_length  = out_res.frame_length;

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking bench for sync_frame_deframer_top: byte stream in, one result per byte out.
// Depends on sfd_pkg, sfd_byte_if, sfd_result_if and the deframer RTL.
`default_nettype none

module testbench;
    import sfd_pkg::*;

    localparam int MAX_LEN = 1024;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // header byte positions after the sync pair
    localparam logic [2:0] HB_VERSION = 3'd0;
    localparam logic [2:0] HB_KIND    = 3'd1;
    localparam logic [2:0] HB_LEN_HI  = 3'd2;
    localparam logic [2:0] HB_LEN_LO  = 3'd3;
    localparam logic [2:0] HB_CK_HI   = 3'd4;

    typedef enum logic [1:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        IN_HEADER,
        IN_PAYLOAD
    } t_hunt;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_index = '0;
    logic [BYTE_W-1:0] i_cfg_data = '0;

    sfd_byte_if   byte_if ();
    sfd_result_if res_if ();

    sync_frame_deframer_top #(
        .MAX_PAYLOAD (MAX_LEN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_byte_ch   (byte_if),
        .o_res_ch    (res_if)
    );

    always #5 i_clk = ~i_clk;

    // deframer mirror: configuration and state
    logic [7:0]  sync_first_r = '0;
    logic [7:0]  sync_second_r = '0;
    logic [7:0]  version_r = '0;
    t_hunt       hunt = HUNT_FIRST;
    logic [2:0]  hdr_idx = '0;
    logic [7:0]  hdr_ver = '0;
    logic [7:0]  kind_q = '0;
    logic [15:0] len_q = '0;
    logic [15:0] ck_q = '0;
    logic [15:0] pay_cnt = '0;
    logic [15:0] sum_q = '0;

    logic [7:0] pending[$];
    t_result    predicted_out[$];

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_off = 1'b0;
    logic byte_taken = 1'b0;
    int   errors = 0;
    event hold_start;

    function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [7:0] b);
        logic [16:0] s;
        s = {1'b0, acc} + {9'd0, b};
        if (s[16])
            s = {1'b0, s[15:0]} + 17'd1;
        return s[15:0];
    endfunction

    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        r.verdict = V_NONE;
        case (hunt)
            HUNT_FIRST: begin
                if (b == sync_first_r)
                    hunt = HUNT_SECOND;
            end
            HUNT_SECOND: begin
                // second sync byte wins when both sync bytes are equal
                if (b == sync_second_r) begin
                    hunt    = IN_HEADER;
                    hdr_idx = '0;
                end else if (b != sync_first_r) begin
                    hunt = HUNT_FIRST;
                end
            end
            IN_HEADER: begin
                case (hdr_idx)
                    HB_VERSION: hdr_ver = b;
                    HB_KIND:    kind_q = b;
                    HB_LEN_HI:  len_q[15:8] = b;
                    HB_LEN_LO:  len_q[7:0] = b;
                    HB_CK_HI:   ck_q[15:8] = b;
                    default:    ck_q[7:0] = b;
                endcase
                if (hdr_idx == HDR_LAST) begin
                    hdr_idx = '0;
                    pay_cnt = '0;
                    sum_q   = '0;
                    if (hdr_ver != version_r || len_q > MAX_LEN) begin
                        hunt      = HUNT_FIRST;
                        r.verdict = V_REJECT;
                    end else if (len_q == 16'd0) begin
                        hunt = HUNT_FIRST;
                        if (ck_q != CHECKSUM_EMPTY) begin
                            r.verdict = V_MISMATCH;
                        end else begin
                            r.verdict    = V_GOOD;
                            r.frame_kind = kind_q;
                        end
                    end else begin
                        hunt = IN_PAYLOAD;
                    end
                end else begin
                    hdr_idx = hdr_idx + 3'd1;
                end
            end
            default: begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                sum_q   = ones_add(sum_q, b);
                pay_cnt = pay_cnt + 16'd1;
                if (pay_cnt >= len_q) begin
                    hunt = HUNT_FIRST;
                    if (~sum_q != ck_q) begin
                        r.verdict = V_MISMATCH;
                    end else begin
                        r.verdict      = V_GOOD;
                        r.frame_kind   = kind_q;
                        r.frame_length = len_q[LEN_OUT_W-1:0];
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Appends one frame (or noise / a broken sync pair) to the byte queue.
    function automatic int queue_frame(input int len, input bit clean);
        logic [7:0]  pay[$];
        logic [7:0]  ver;
        logic [7:0]  b;
        logic [15:0] acc;
        logic [15:0] ck;
        logic [15:0] len16;
        int          start;
        int          r;
        start = pending.size();
        r     = $urandom_range(0, 99);
        len16 = 16'(len);
        if (!clean && r < 8) begin
            repeat ($urandom_range(1, 4)) pending.push_back(8'($urandom));
            return pending.size() - start;
        end
        if (!clean && r < 14) begin
            do b = 8'($urandom); while (b == sync_first_r || b == sync_second_r);
            pending.push_back(sync_first_r);
            pending.push_back(b);
            return pending.size() - start;
        end
        if (!clean && sync_first_r != sync_second_r && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) pending.push_back(sync_first_r);
        pending.push_back(sync_first_r);
        pending.push_back(sync_second_r);
        ver = version_r;
        if (!clean && $urandom_range(0, 9) == 0)
            ver = version_r ^ 8'($urandom_range(1, 255));
        acc = '0;
        if (ver == version_r && len16 <= MAX_LEN) begin
            repeat (len) begin
                b = 8'($urandom);
                pay.push_back(b);
                acc = ones_add(acc, b);
            end
        end
        ck = ~acc;
        if (!clean && $urandom_range(0, 6) == 0)
            ck = ck ^ 16'($urandom_range(1, 65535));
        pending.push_back(ver);
        pending.push_back(8'($urandom));
        pending.push_back(len16[15:8]);
        pending.push_back(len16[7:0]);
        pending.push_back(ck[15:8]);
        pending.push_back(ck[7:0]);
        foreach (pay[i]) pending.push_back(pay[i]);
        return pending.size() - start;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_SYNC_FIRST:       sync_first_r = val;
            CFG_SYNC_SECOND:      sync_second_r = val;
            CFG_VERSION_EXPECTED: version_r = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending.size() != 0 || byte_if.valid || predicted_out.size() != 0);
    endtask

    task automatic check_field(input string fname, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            if (errors < 60)
                $display("%0t mismatch %s: expected %0h actual %0h", $time, fname, exp_v, got_v);
            errors++;
        end
    endtask

    task automatic run_phase(input logic [7:0] first, input logic [7:0] second,
                             input logic [7:0] ver, input int send_pct, input int recv_pct,
                             input int budget, input bit with_hold, input bit with_max);
        int count;
        write_reg(CFG_SYNC_FIRST, first);
        write_reg(CFG_SYNC_SECOND, second);
        write_reg(CFG_VERSION_EXPECTED, ver);
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        count = 0;
        if (with_max)
            count += queue_frame(MAX_LEN, 1'b1);
        while (count < budget) begin
            int r;
            int len;
            r = $urandom_range(0, 99);
            if (r < 65)
                len = $urandom_range(0, 16);
            else if (r < 93)
                len = $urandom_range(17, 64);
            else
                len = $urandom_range(MAX_LEN + 1, 65535);
            count += queue_frame(len, 1'b0);
        end
        if (with_hold) begin
            // receiver holds off while the sender keeps offering; input must back up
            -> hold_start;
        end
        wait_drained();
    endtask

    always begin : hold_timer
        @(hold_start);
        hold_off <= 1'b1;
        repeat (64) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(negedge i_clk) begin : drive_bytes
        if (!byte_if.valid || byte_taken) begin
            if (i_rst_n && pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                byte_if.valid     <= 1'b1;
                byte_if.data_byte <= pending.pop_front();
            end else begin
                byte_if.valid     <= 1'b0;
                byte_if.data_byte <= 8'($urandom);
            end
        end
    end

    always @(negedge i_clk) begin : drive_ready
        res_if.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : take_and_check
        t_result want;
        byte_taken <= byte_if.valid && byte_if.ready;
        if (i_rst_n && byte_if.valid && byte_if.ready)
            predicted_out.push_back(deframe_byte(byte_if.data_byte));
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (predicted_out.size() == 0) begin
                if (errors < 60)
                    $display("%0t unexpected result: verdict %0d byte %0h", $time,
                             res_if.verdict, res_if.payload_byte);
                errors++;
            end else begin
                want = predicted_out.pop_front();
                check_field("payload_valid", want.payload_valid, res_if.payload_valid);
                check_field("payload_byte", want.payload_byte, res_if.payload_byte);
                check_field("verdict", want.verdict, res_if.verdict);
                check_field("frame_kind", want.frame_kind, res_if.frame_kind);
                check_field("frame_length", want.frame_length, res_if.frame_length);
            end
        end
    end

    initial begin : stimulus
        logic [7:0] zero_cfg_bytes [8];
        logic [7:0] equal_sync_bytes [17];
        zero_cfg_bytes = '{8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 8'hff};
        // equal sync bytes, one-byte frame (echo and verdict together), bad version
        equal_sync_bytes = '{8'hff, 8'hff, 8'hff, 8'h80, 8'h00, 8'h01, 8'hff, 8'h00, 8'hff,
                             8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff};
        byte_if.valid     = 1'b0;
        byte_if.data_byte = '0;
        res_if.ready      = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: empty frame with sync bytes of zero
        @(posedge i_clk);
        foreach (zero_cfg_bytes[i]) pending.push_back(zero_cfg_bytes[i]);
        wait_drained();
        write_reg(CFG_SYNC_FIRST, 8'hff);
        write_reg(CFG_SYNC_SECOND, 8'hff);
        write_reg(CFG_VERSION_EXPECTED, 8'hff);
        @(posedge i_clk);
        foreach (equal_sync_bytes[i]) pending.push_back(equal_sync_bytes[i]);
        wait_drained();

        run_phase(8'ha5, 8'h5a, 8'h01, 0, 0, 230, 1'b0, 1'b0);
        write_reg(CFG_UNUSED, 8'($urandom));
        run_phase(8'h00, 8'hff, 8'h00, 45, 0, 230, 1'b0, 1'b0);
        run_phase(8'hff, 8'h00, 8'hff, 0, 45, 230, 1'b0, 1'b0);
        run_phase(8'($urandom), 8'($urandom), 8'($urandom), 14, 14, 230, 1'b1, 1'b0);
        run_phase(8'h3c, 8'h3c, 8'($urandom), 14, 14, 1050, 1'b0, 1'b1);

        repeat (16) @(posedge i_clk);
        if (errors == 0 && predicted_out.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
